// File: rtl/ilcc_pkg.sv
// ----------------------------------------------------------------------------
// ilcc_pkg
// types, codes and frame geometry shared by the image link capture controller
// ----------------------------------------------------------------------------
package ilcc_pkg;

  // frame geometry
  localparam int unsigned FRAME_BYTES = 38400;
  localparam int unsigned CHUNK_BYTES = 1264;
  localparam int unsigned CHUNK_CNT   = (FRAME_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;

  // field widths
  localparam int unsigned CHUNK_W  = 5;
  localparam int unsigned OFF_W    = 18;  // holds 31 * 4096
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 80;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_RUN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VITALS_PER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_GAP    = 3'd4;

  localparam logic [7:0] TARGET_NONE  = 8'h00;
  localparam logic [7:0] TARGET_BCAST = 8'hFF;

  // configuration reset values
  localparam logic [7:0]       RST_NODE_TARGET = 8'd1;
  localparam logic             RST_FREE_RUN    = 1'b1;
  localparam logic [CFG_W-1:0] RST_VITALS_PER  = 16'd1000;
  localparam logic [CFG_W-1:0] RST_SETTLE      = 16'd1000;
  localparam logic [CFG_W-1:0] RST_IMAGE_GAP   = 16'd0;

  typedef enum logic [1:0] {
    EV_PACKET  = 2'd0,
    EV_POLL    = 2'd1,
    EV_TX_DONE = 2'd2,
    EV_SPARE   = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    PK_COMMAND   = 3'd0,
    PK_VITALS    = 3'd1,
    PK_GO        = 3'd2,
    PK_STOP      = 3'd3,
    PK_STOP_LOSS = 3'd4,
    PK_OTHER     = 3'd5
  } pkt_kind_t;

  typedef enum logic [2:0] {
    CMD_FFC        = 3'd0,
    CMD_TAKE_IMAGE = 3'd1,
    CMD_START_REC  = 3'd2,
    CMD_STOP_REC   = 3'd3,
    CMD_STREAM_OFF = 3'd4,
    CMD_STREAM_ON  = 3'd5,
    CMD_DOSE_ZERO  = 3'd6,
    CMD_UNKNOWN    = 3'd7
  } cmd_code_t;

  typedef enum logic [1:0] {
    TX_NONE   = 2'd0,
    TX_ACK    = 2'd1,
    TX_VITALS = 2'd2,
    TX_CHUNK  = 2'd3
  } send_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_CORRECT = 2'd1,
    MODE_SINGLE  = 2'd2,
    MODE_RECORD  = 2'd3
  } cap_mode_t;

  typedef struct packed {
    logic [7:0]       node_target;
    logic             free_run;
    logic [CFG_W-1:0] vitals_period_ms;
    logic [CFG_W-1:0] settle_ms;
    logic [CFG_W-1:0] image_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic [7:0]  pkt_target;
    logic [2:0]  pkt_kind;
    logic        pkt_has_payload;
    logic [2:0]  cmd_code;
    logic        frame_available;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         send_kind;
    logic [CHUNK_W-1:0] chunk_number;
    logic [CHUNK_W-1:0] chunk_count;
    logic [15:0]        chunk_offset;
    logic [10:0]        chunk_length;
    logic               last_chunk;
    logic               start_correction;
    logic               start_dose_zero;
    logic [1:0]         capture_mode;
    logic               stream_on;
    logic [15:0]        images_done;
    logic [15:0]        rejected_count;
  } result_t;

endpackage

// File: rtl/image_link_capture_controller.sv
// ----------------------------------------------------------------------------
// image_link_capture_controller
// downlink controller of a camera node: packets, polls and transmit events
// ----------------------------------------------------------------------------
// Each request on the input stream is one event: a decoded packet, a scheduler
// poll or a transmit-done notice, and each produces exactly one result. The
// block takes one request per clock: an accepted request is held in the input
// register, then the controller update lands in the result register, from
// which the result is offered. The rate is one request per cycle, set by the
// single controller state update; it drops only while the result side stalls.
// Configuration must be written through the plain write port only while the
// block is idle; the block itself does not enforce this. Target ids 0 and
// 0xFF are ignored.
// ----------------------------------------------------------------------------
module image_link_capture_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata, lowest bit up: now_ms[31:0], pkt_target[39:32], pkt_kind[42:40],
  // pkt_has_payload[43], cmd_code[46:44], frame_available[47]
  input  logic [ilcc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: command[1:0]
  input  logic [1:0]                        in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata, lowest bit up: chunk_number[4:0], chunk_count[9:5],
  // chunk_offset[25:10], chunk_length[36:26], start_correction[37],
  // start_dose_zero[38], capture_mode[40:39], stream_on[41],
  // images_done[57:42], rejected_count[73:58], zero fill to bit 79
  output logic [ilcc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser: send_kind[1:0]
  output logic [1:0]                        out_tuser,
  // last chunk of the frame
  output logic                              out_tlast,
  // configuration
  input  logic                              cfg_we,
  input  logic [ilcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ilcc_pkg::CFG_W-1:0]        cfg_wdata
);
  import ilcc_pkg::*;

  cfg_t     cfg;
  in_item_t in_item_r, in_item_nxt;
  logic     in_valid_r, in_valid_nxt;
  result_t  res;
  result_t  out_res_r, out_res_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     fire;

  // request in the input register moves on when the result slot frees up
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  // unpack the incoming request
  always_comb begin
    in_item_nxt                 = in_item_r;
    in_valid_nxt                = in_valid_r;
    if (in_tready) begin
      in_valid_nxt                = in_tvalid;
      in_item_nxt.command         = in_tuser;
      in_item_nxt.now_ms          = in_tdata[31:0];
      in_item_nxt.pkt_target      = in_tdata[39:32];
      in_item_nxt.pkt_kind        = in_tdata[42:40];
      in_item_nxt.pkt_has_payload = in_tdata[43];
      in_item_nxt.cmd_code        = in_tdata[46:44];
      in_item_nxt.frame_available = in_tdata[47];
    end
  end

  // result register holds until the consumer takes it
  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_res_nxt   = res;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  ilcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ilcc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.send_kind;
  assign out_tlast  = out_res_r.last_chunk;
  assign out_tdata  = {6'd0,
                       out_res_r.rejected_count,
                       out_res_r.images_done,
                       out_res_r.stream_on,
                       out_res_r.capture_mode,
                       out_res_r.start_dose_zero,
                       out_res_r.start_correction,
                       out_res_r.chunk_length,
                       out_res_r.chunk_offset,
                       out_res_r.chunk_count,
                       out_res_r.chunk_number};

endmodule

// File: rtl/ilcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ilcc_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module ilcc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ilcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ilcc_pkg::CFG_W-1:0]     cfg_wdata,
  output ilcc_pkg::cfg_t                cfg
);
  import ilcc_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic [7:0] target_wr;

  assign target_wr = cfg_wdata[7:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_TARGET: begin
          // reserved ids keep the previous target
          if (target_wr != TARGET_NONE && target_wr != TARGET_BCAST) begin
            cfg_nxt.node_target = target_wr;
          end
        end
        REG_FREE_RUN:   cfg_nxt.free_run         = cfg_wdata[0];
        REG_VITALS_PER: cfg_nxt.vitals_period_ms = cfg_wdata;
        REG_SETTLE:     cfg_nxt.settle_ms        = cfg_wdata;
        REG_IMAGE_GAP:  cfg_nxt.image_gap_ms     = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_target      <= RST_NODE_TARGET;
      cfg_r.free_run         <= RST_FREE_RUN;
      cfg_r.vitals_period_ms <= RST_VITALS_PER;
      cfg_r.settle_ms        <= RST_SETTLE;
      cfg_r.image_gap_ms     <= RST_IMAGE_GAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/ilcc_ctrl.sv
// ----------------------------------------------------------------------------
// ilcc_ctrl
// controller state and per-request update, result formed combinationally
// ----------------------------------------------------------------------------
module ilcc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ilcc_pkg::in_item_t item,
  input  ilcc_pkg::cfg_t     cfg,
  output ilcc_pkg::result_t  res
);
  import ilcc_pkg::*;

  logic               stream_r, stream_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic               single_r, single_nxt;
  logic [1:0]         pend_r, pend_nxt;
  logic               armed_r, armed_nxt;
  logic [31:0]        deadline_r, deadline_nxt;
  logic               ack_owed_r, ack_owed_nxt;
  logic               vit_owed_r, vit_owed_nxt;
  logic               tx_busy_r, tx_busy_nxt;
  logic [31:0]        last_vit_r, last_vit_nxt;
  logic [31:0]        last_img_r, last_img_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [15:0]        img_cnt_r, img_cnt_nxt;
  logic [15:0]        rej_cnt_r, rej_cnt_nxt;

  logic [31:0]    settle_diff;
  logic           vit_due;
  logic           img_due;
  logic [OFF_W-1:0] offset;
  logic [OFF_W-1:0] remaining;
  logic           in_frame;
  logic           is_final;

  always_comb begin
    stream_nxt   = stream_r;
    mode_nxt     = mode_r;
    single_nxt   = single_r;
    pend_nxt     = pend_r;
    armed_nxt    = armed_r;
    deadline_nxt = deadline_r;
    ack_owed_nxt = ack_owed_r;
    vit_owed_nxt = vit_owed_r;
    tx_busy_nxt  = tx_busy_r;
    last_vit_nxt = last_vit_r;
    last_img_nxt = last_img_r;
    chunk_nxt    = chunk_r;
    img_cnt_nxt  = img_cnt_r;
    rej_cnt_nxt  = rej_cnt_r;

    res = '0;

    settle_diff = item.now_ms - deadline_r;
    vit_due     = (item.now_ms - last_vit_r) >= {16'd0, cfg.vitals_period_ms};
    img_due     = (item.now_ms - last_img_r) >= {16'd0, cfg.image_gap_ms};
    offset      = '0;
    remaining   = '0;
    in_frame    = 1'b0;
    is_final    = 1'b0;

    unique case (event_t'(item.command))
      EV_PACKET: begin
        if (item.pkt_target != cfg.node_target) begin
          rej_cnt_nxt = rej_cnt_r + 16'd1;
        end else begin
          case (pkt_kind_t'(item.pkt_kind)) inside
            PK_COMMAND: begin
              if (item.pkt_has_payload) begin
                case (cmd_code_t'(item.cmd_code)) inside
                  CMD_FFC: res.start_correction = 1'b1;
                  CMD_TAKE_IMAGE, CMD_START_REC: begin
                    // correction first, capture starts once it has settled
                    res.start_correction = 1'b1;
                    deadline_nxt = item.now_ms + {16'd0, cfg.settle_ms};
                    armed_nxt    = 1'b1;
                    mode_nxt     = MODE_CORRECT;
                    stream_nxt   = 1'b0;
                    single_nxt   = (item.cmd_code == CMD_TAKE_IMAGE);
                    chunk_nxt    = '0;
                    pend_nxt     = (item.cmd_code == CMD_TAKE_IMAGE) ? MODE_SINGLE
                                                                     : MODE_RECORD;
                  end
                  CMD_STOP_REC, CMD_STREAM_OFF: begin
                    stream_nxt   = 1'b0;
                    single_nxt   = 1'b0;
                    armed_nxt    = 1'b0;
                    deadline_nxt = '0;
                    mode_nxt     = MODE_IDLE;
                    chunk_nxt    = '0;
                  end
                  CMD_STREAM_ON: begin
                    single_nxt   = 1'b0;
                    armed_nxt    = 1'b0;
                    deadline_nxt = '0;
                    stream_nxt   = 1'b1;
                    mode_nxt     = MODE_RECORD;
                  end
                  CMD_DOSE_ZERO: res.start_dose_zero = 1'b1;
                  default: ;
                endcase
              end
              ack_owed_nxt = 1'b1;
            end
            PK_VITALS: vit_owed_nxt = 1'b1;
            PK_GO: begin
              stream_nxt = 1'b1;
              mode_nxt   = MODE_RECORD;
            end
            PK_STOP, PK_STOP_LOSS: begin
              stream_nxt   = 1'b0;
              single_nxt   = 1'b0;
              armed_nxt    = 1'b0;
              deadline_nxt = '0;
              mode_nxt     = MODE_IDLE;
              chunk_nxt    = '0;
            end
            default: ;
          endcase
        end
      end
      EV_POLL: begin
        if (!tx_busy_r) begin
          // settle deadline reached: wrap-safe signed compare
          if (armed_r && !settle_diff[31]) begin
            armed_nxt    = 1'b0;
            deadline_nxt = '0;
            chunk_nxt    = '0;
            stream_nxt   = 1'b1;
            mode_nxt     = pend_r;
          end
          offset    = OFF_W'(chunk_nxt) * OFF_W'(CHUNK_BYTES);
          in_frame  = offset < OFF_W'(FRAME_BYTES);
          remaining = OFF_W'(FRAME_BYTES) - offset;
          is_final  = remaining <= OFF_W'(CHUNK_BYTES);
          if (ack_owed_r) begin
            ack_owed_nxt  = 1'b0;
            tx_busy_nxt   = 1'b1;
            res.send_kind = TX_ACK;
          end else if (vit_owed_r) begin
            vit_owed_nxt  = 1'b0;
            last_vit_nxt  = item.now_ms;
            tx_busy_nxt   = 1'b1;
            res.send_kind = TX_VITALS;
          end else if (cfg.free_run && vit_due) begin
            last_vit_nxt  = item.now_ms;
            tx_busy_nxt   = 1'b1;
            res.send_kind = TX_VITALS;
          end else if (stream_nxt && img_due) begin
            last_img_nxt = item.now_ms;
            if (item.frame_available && in_frame) begin
              res.send_kind    = TX_CHUNK;
              tx_busy_nxt      = 1'b1;
              res.chunk_number = chunk_nxt;
              res.chunk_count  = CHUNK_W'(CHUNK_CNT);
              res.chunk_offset = offset[15:0];
              res.chunk_length = is_final ? remaining[10:0] : 11'(CHUNK_BYTES);
              res.last_chunk   = is_final;
              chunk_nxt        = is_final ? '0 : chunk_nxt + 1'b1;
              if (is_final && single_r) begin
                single_nxt  = 1'b0;
                stream_nxt  = 1'b0;
                mode_nxt    = MODE_IDLE;
                img_cnt_nxt = img_cnt_r + 16'd1;
              end
            end
          end
        end
      end
      EV_TX_DONE: tx_busy_nxt = 1'b0;
      default: ;
    endcase

    res.capture_mode   = mode_nxt;
    res.stream_on      = stream_nxt;
    res.images_done    = img_cnt_nxt;
    res.rejected_count = rej_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_r   <= RST_FREE_RUN;
      mode_r     <= RST_FREE_RUN ? MODE_RECORD : MODE_IDLE;
      single_r   <= 1'b0;
      pend_r     <= MODE_IDLE;
      armed_r    <= 1'b0;
      deadline_r <= '0;
      ack_owed_r <= 1'b0;
      vit_owed_r <= 1'b0;
      tx_busy_r  <= 1'b0;
      last_vit_r <= '0;
      last_img_r <= '0;
      chunk_r    <= '0;
      img_cnt_r  <= '0;
      rej_cnt_r  <= '0;
    end else if (fire) begin
      stream_r   <= stream_nxt;
      mode_r     <= mode_nxt;
      single_r   <= single_nxt;
      pend_r     <= pend_nxt;
      armed_r    <= armed_nxt;
      deadline_r <= deadline_nxt;
      ack_owed_r <= ack_owed_nxt;
      vit_owed_r <= vit_owed_nxt;
      tx_busy_r  <= tx_busy_nxt;
      last_vit_r <= last_vit_nxt;
      last_img_r <= last_img_nxt;
      chunk_r    <= chunk_nxt;
      img_cnt_r  <= img_cnt_nxt;
      rej_cnt_r  <= rej_cnt_nxt;
    end
  end

endmodule

// File: dv/ilcc_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilcc_sb_pkg
// predicts the status reply of every downlink event and checks the replies
// ----------------------------------------------------------------------------
package ilcc_sb_pkg;
  import ilcc_pkg::*;

  class downlink_scoreboard;
    // register copies
    logic [7:0]       node_target;
    bit               free_run;
    logic [CFG_W-1:0] vitals_period;
    logic [CFG_W-1:0] settle_wait;
    logic [CFG_W-1:0] image_gap;

    // controller state
    bit               stream_en;
    bit               single_burst;
    bit               settle_armed;
    bit               ack_owed;
    bit               vitals_owed;
    bit               tx_busy;
    cap_mode_t        mode;
    cap_mode_t        pending_mode;
    logic [31:0]      settle_deadline;
    logic [31:0]      last_vitals;
    logic [31:0]      last_image;
    logic [4:0]       next_chunk;
    logic [15:0]      images_done;
    logic [15:0]      rejected;

    result_t          owed_replies[$];
    int               errors;

    function new();
      node_target     = RST_NODE_TARGET;
      free_run        = RST_FREE_RUN;
      vitals_period   = RST_VITALS_PER;
      settle_wait     = RST_SETTLE;
      image_gap       = RST_IMAGE_GAP;
      stream_en       = RST_FREE_RUN;
      mode            = RST_FREE_RUN ? MODE_RECORD : MODE_IDLE;
      single_burst    = 1'b0;
      pending_mode    = MODE_IDLE;
      settle_deadline = '0;
      settle_armed    = 1'b0;
      ack_owed        = 1'b0;
      vitals_owed     = 1'b0;
      tx_busy         = 1'b0;
      last_vitals     = '0;
      last_image      = '0;
      next_chunk      = '0;
      images_done     = '0;
      rejected        = '0;
      errors          = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_NODE_TARGET: begin
          // no-target and broadcast ids are refused
          if (val[7:0] != TARGET_NONE && val[7:0] != TARGET_BCAST) node_target = val[7:0];
        end
        REG_FREE_RUN:   free_run = val[0];
        REG_VITALS_PER: vitals_period = val;
        REG_SETTLE:     settle_wait = val;
        REG_IMAGE_GAP:  image_gap = val;
        default: ;
      endcase
    endfunction

    function void halt_capture();
      stream_en       = 1'b0;
      single_burst    = 1'b0;
      settle_armed    = 1'b0;
      settle_deadline = '0;
      mode            = MODE_IDLE;
      next_chunk      = '0;
    endfunction

    function void arm_settle(logic [31:0] now, cap_mode_t target_mode);
      settle_deadline = now + {16'd0, settle_wait};
      settle_armed    = 1'b1;
      mode            = MODE_CORRECT;
      stream_en       = 1'b0;
      single_burst    = (target_mode == MODE_SINGLE);
      next_chunk      = '0;
      pending_mode    = target_mode;
    endfunction

    // work out the reply to one accepted event and queue it
    function void apply_event(in_item_t ev);
      result_t     r;
      logic [31:0] to_deadline;
      logic [31:0] since_vitals;
      logic [31:0] since_image;
      logic [31:0] offs;
      logic [31:0] remain;
      r = '0;
      case (ev.command)
        EV_PACKET: begin
          if (ev.pkt_target != node_target) begin
            rejected = rejected + 16'd1;
          end else begin
            case (ev.pkt_kind) inside
              PK_COMMAND: begin
                if (ev.pkt_has_payload) begin
                  case (ev.cmd_code) inside
                    CMD_FFC: r.start_correction = 1'b1;
                    CMD_TAKE_IMAGE: begin
                      r.start_correction = 1'b1;
                      arm_settle(ev.now_ms, MODE_SINGLE);
                    end
                    CMD_START_REC: begin
                      r.start_correction = 1'b1;
                      arm_settle(ev.now_ms, MODE_RECORD);
                    end
                    CMD_STOP_REC, CMD_STREAM_OFF: halt_capture();
                    CMD_STREAM_ON: begin
                      single_burst    = 1'b0;
                      settle_armed    = 1'b0;
                      settle_deadline = '0;
                      stream_en       = 1'b1;
                      mode            = MODE_RECORD;
                    end
                    CMD_DOSE_ZERO: r.start_dose_zero = 1'b1;
                    default: ;
                  endcase
                end
                ack_owed = 1'b1;
              end
              PK_VITALS: vitals_owed = 1'b1;
              PK_GO: begin
                stream_en = 1'b1;
                mode      = MODE_RECORD;
              end
              PK_STOP, PK_STOP_LOSS: halt_capture();
              default: ;
            endcase
          end
        end
        EV_POLL: begin
          if (!tx_busy) begin
            to_deadline  = ev.now_ms - settle_deadline;
            since_vitals = ev.now_ms - last_vitals;
            since_image  = ev.now_ms - last_image;
            // deadline reached once the signed distance is not negative
            if (settle_armed && !to_deadline[31]) begin
              settle_armed    = 1'b0;
              settle_deadline = '0;
              next_chunk      = '0;
              stream_en       = 1'b1;
              mode            = pending_mode;
            end
            if (ack_owed) begin
              ack_owed    = 1'b0;
              tx_busy     = 1'b1;
              r.send_kind = TX_ACK;
            end else if (vitals_owed) begin
              vitals_owed = 1'b0;
              last_vitals = ev.now_ms;
              tx_busy     = 1'b1;
              r.send_kind = TX_VITALS;
            end else if (free_run && since_vitals >= {16'd0, vitals_period}) begin
              last_vitals = ev.now_ms;
              tx_busy     = 1'b1;
              r.send_kind = TX_VITALS;
            end else if (stream_en && since_image >= {16'd0, image_gap}) begin
              offs       = next_chunk * CHUNK_BYTES;
              last_image = ev.now_ms;
              if (ev.frame_available && offs < FRAME_BYTES) begin
                remain         = FRAME_BYTES - offs;
                r.send_kind    = TX_CHUNK;
                tx_busy        = 1'b1;
                r.chunk_number = next_chunk;
                r.chunk_count  = 5'(CHUNK_CNT);
                r.chunk_offset = offs[15:0];
                r.chunk_length = (remain < CHUNK_BYTES) ? remain[10:0] : 11'(CHUNK_BYTES);
                r.last_chunk   = (remain <= CHUNK_BYTES);
                next_chunk     = r.last_chunk ? 5'd0 : next_chunk + 5'd1;
                if (r.last_chunk && single_burst) begin
                  single_burst = 1'b0;
                  stream_en    = 1'b0;
                  mode         = MODE_IDLE;
                  images_done  = images_done + 16'd1;
                end
              end
            end
          end
        end
        EV_TX_DONE: tx_busy = 1'b0;
        default: ;
      endcase
      r.capture_mode   = mode;
      r.stream_on      = stream_en;
      r.images_done    = images_done;
      r.rejected_count = rejected;
      owed_replies.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (owed_replies.size() == 0) begin
        $error("reply with no request outstanding");
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      cmp("send_kind",        want.send_kind,        got.send_kind);
      cmp("chunk_number",     want.chunk_number,     got.chunk_number);
      cmp("chunk_count",      want.chunk_count,      got.chunk_count);
      cmp("chunk_offset",     want.chunk_offset,     got.chunk_offset);
      cmp("chunk_length",     want.chunk_length,     got.chunk_length);
      cmp("last_chunk",       want.last_chunk,       got.last_chunk);
      cmp("start_correction", want.start_correction, got.start_correction);
      cmp("start_dose_zero",  want.start_dose_zero,  got.start_dose_zero);
      cmp("capture_mode",     want.capture_mode,     got.capture_mode);
      cmp("stream_on",        want.stream_on,        got.stream_on);
      cmp("images_done",      want.images_done,      got.images_done);
      cmp("rejected_count",   want.rejected_count,   got.rejected_count);
    endfunction

    function int outstanding();
      return owed_replies.size();
    endfunction
  endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the image link capture controller
// ----------------------------------------------------------------------------
// A short directed run covers the reset settings, rejection, the spare event
// code, busy polls, a settle deadline on tick zero and a poll with no frame.
// Then four phases of random requests follow, each under its own register
// settings and back-pressure mix. Every request is predicted by the
// scoreboard and every reply is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import ilcc_pkg::*;
  import ilcc_sb_pkg::*;

  // a reply passes the input and result registers; long stalls are geometric
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int ITEMS_PER_PHASE = 106;
  localparam int TAIL_CYCLES     = 10;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [1:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  // idling mix of the current phase, in percent of cycles
  int                     sender_idle_pct = 0;
  int                     stall_pct       = 0;
  // millisecond tick carried by random requests
  logic [31:0]            tb_now          = '0;
  // target id the node currently answers to
  logic [7:0]             cur_target      = RST_NODE_TARGET;
  int                     quiet_cycles    = 0;
  result_t                seen;
  downlink_scoreboard     sb;

  always #2 clk = ~clk;

  image_link_capture_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // offer one request after a random idle gap and hold it until taken
  task automatic push_request(input in_item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.command;
    in_tdata  <= {it.frame_available, it.cmd_code, it.pkt_has_payload,
                  it.pkt_kind, it.pkt_target, it.now_ms};
    do @(posedge clk); while (!in_tready);
    sb.apply_event(it);
  endtask

  // stop offering and let every owed reply come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // one register write; the caller drops the write enable afterwards
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // register settings and idling mix of each random phase
  task automatic program_phase(input int p);
    case (p)
      0: begin
        // reset settings, no idling on either side
        sender_idle_pct = 0;
        stall_pct       = 0;
      end
      1: begin
        sender_idle_pct = 69;
        stall_pct       = 0;
        // no-target and broadcast ids must be ignored
        cfg_write(REG_NODE_TARGET, {8'd0, TARGET_NONE});
        cfg_write(REG_NODE_TARGET, {8'd0, TARGET_BCAST});
        cfg_write(REG_NODE_TARGET, 16'd254);
        cfg_write(REG_FREE_RUN, 16'd0);
        cfg_write(REG_VITALS_PER, 16'd1);
        cfg_write(REG_SETTLE, 16'd0);
        cfg_write(REG_IMAGE_GAP, 16'd0);
        cur_target = 8'd254;
      end
      2: begin
        sender_idle_pct = 0;
        stall_pct       = 69;
        // zero period: vitals on every idle poll in free run
        cfg_write(REG_NODE_TARGET, 16'd1);
        cfg_write(REG_FREE_RUN, 16'd1);
        cfg_write(REG_VITALS_PER, 16'd0);
        cfg_write(REG_SETTLE, 16'hFFFF);
        cfg_write(REG_IMAGE_GAP, 16'hFFFF);
        cur_target = 8'd1;
      end
      default: begin
        sender_idle_pct = 35;
        stall_pct       = 35;
        cfg_write(REG_NODE_TARGET, 16'd77);
        cfg_write(REG_FREE_RUN, 16'd1);
        cfg_write(REG_VITALS_PER, 16'hFFFF);
        cfg_write(REG_SETTLE, 16'd20);
        cfg_write(REG_IMAGE_GAP, 16'd3);
        cur_target = 8'd77;
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t mk(event_t ev, logic [31:0] now, logic [7:0] tgt,
                                  pkt_kind_t kind, cmd_code_t code, bit pay, bit frame);
    in_item_t it;
    it.command         = ev;
    it.now_ms          = now;
    it.pkt_target      = tgt;
    it.pkt_kind        = kind;
    it.pkt_has_payload = pay;
    it.cmd_code        = code;
    it.frame_available = frame;
    return it;
  endfunction

  // mostly poll / transmit-done traffic with own commands mixed in, some noise
  function automatic in_item_t random_request();
    in_item_t it;
    int       r;
    // tick: mostly small steps, sometimes long gaps or a jump anywhere
    r = $urandom_range(0, 99);
    if (r < 2) tb_now = $urandom();
    else if (r < 6) tb_now += $urandom_range(1000, 70000);
    else if (r >= 20) tb_now += $urandom_range(1, 60);
    it.now_ms          = tb_now;
    it.pkt_target      = $urandom_range(0, 255);
    it.pkt_kind        = $urandom_range(0, 5);
    it.pkt_has_payload = $urandom_range(0, 1);
    it.cmd_code        = $urandom_range(0, 7);
    it.frame_available = ($urandom_range(0, 99) < 92);
    r = $urandom_range(0, 99);
    if (r < 42) begin
      it.command = EV_POLL;
    end else if (r < 78) begin
      it.command = EV_TX_DONE;
    end else if (r < 86) begin
      // packet for this node; halts kept rare so frames can finish
      it.command         = EV_PACKET;
      it.pkt_target      = cur_target;
      it.pkt_has_payload = ($urandom_range(0, 9) != 0);
      r = $urandom_range(0, 99);
      if (r < 55) it.pkt_kind = PK_COMMAND;
      else if (r < 75) it.pkt_kind = PK_VITALS;
      else if (r < 82) it.pkt_kind = PK_GO;
      else if (r < 87) it.pkt_kind = PK_STOP;
      else if (r < 91) it.pkt_kind = PK_STOP_LOSS;
      else it.pkt_kind = $urandom_range(5, 7);
      r = $urandom_range(0, 99);
      if (r < 18) it.cmd_code = CMD_TAKE_IMAGE;
      else if (r < 32) it.cmd_code = CMD_START_REC;
      else if (r < 47) it.cmd_code = CMD_FFC;
      else if (r < 60) it.cmd_code = CMD_DOSE_ZERO;
      else if (r < 70) it.cmd_code = CMD_STREAM_ON;
      else if (r < 75) it.cmd_code = CMD_STOP_REC;
      else if (r < 80) it.cmd_code = CMD_STREAM_OFF;
      else it.cmd_code = CMD_UNKNOWN;
    end else if (r < 91) begin
      // packet for some other node
      it.command = EV_PACKET;
      if (it.pkt_target == cur_target) it.pkt_target = ~cur_target;
    end else begin
      // noise: any event code, any kind
      it.command  = $urandom_range(0, 3);
      it.pkt_kind = $urandom_range(0, 7);
    end
    return it;
  endfunction

  // result side: check on every accepted reply, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.send_kind        = out_tuser;
        seen.chunk_number     = out_tdata[4:0];
        seen.chunk_count      = out_tdata[9:5];
        seen.chunk_offset     = out_tdata[25:10];
        seen.chunk_length     = out_tdata[36:26];
        seen.last_chunk       = out_tlast;
        seen.start_correction = out_tdata[37];
        seen.start_dose_zero  = out_tdata[38];
        seen.capture_mode     = out_tdata[40:39];
        seen.stream_on        = out_tdata[41];
        seen.images_done      = out_tdata[57:42];
        seen.rejected_count   = out_tdata[73:58];
        sb.check_reply(seen);
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog: too long with nothing moving on either stream
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset settings: free run, stream on, recording
    // first chunk straight from reset, then a poll while still transmitting
    push_request(mk(EV_POLL,    32'd0, 8'd0,   PK_COMMAND, CMD_FFC,     1'b0, 1'b1));
    push_request(mk(EV_POLL,    32'd3, 8'd0,   PK_COMMAND, CMD_FFC,     1'b0, 1'b1));
    push_request(mk(EV_TX_DONE, 32'd4, 8'd0,   PK_COMMAND, CMD_FFC,     1'b0, 1'b0));
    // foreign targets at both ends of the id range
    push_request(mk(EV_PACKET,  32'd8, 8'hFF,  PK_COMMAND, CMD_FFC,     1'b1, 1'b0));
    push_request(mk(EV_PACKET,  32'd9, 8'h00,  PK_GO,      CMD_FFC,     1'b1, 1'b0));
    // spare event code with every field at its top: no effect
    push_request(mk(EV_SPARE,   32'hFFFF_FFFF, 8'hFF, PK_OTHER, CMD_UNKNOWN, 1'b1, 1'b1));
    // correction command and vitals request, then drained by polls in order
    push_request(mk(EV_PACKET,  32'd11, 8'd1,  PK_COMMAND, CMD_FFC,     1'b1, 1'b0));
    push_request(mk(EV_PACKET,  32'd12, 8'd1,  PK_VITALS,  CMD_FFC,     1'b0, 1'b0));
    push_request(mk(EV_POLL,    32'd13, 8'd0,  PK_COMMAND, CMD_FFC,     1'b0, 1'b1));
    push_request(mk(EV_TX_DONE, 32'd14, 8'd0,  PK_COMMAND, CMD_FFC,     1'b0, 1'b0));
    push_request(mk(EV_POLL,    32'd15, 8'd0,  PK_COMMAND, CMD_FFC,     1'b0, 1'b1));
    push_request(mk(EV_TX_DONE, 32'd16, 8'd0,  PK_COMMAND, CMD_FFC,     1'b0, 1'b0));
    push_request(mk(EV_PACKET,  32'd17, 8'd1,  PK_COMMAND, CMD_DOSE_ZERO, 1'b1, 1'b0));
    // command packet without a command byte still owes an ack
    push_request(mk(EV_PACKET,  32'd18, 8'd1,  PK_COMMAND, CMD_UNKNOWN, 1'b0, 1'b0));
    // single capture whose settle deadline wraps onto tick zero
    push_request(mk(EV_PACKET,  32'hFFFF_FC18, 8'd1, PK_COMMAND, CMD_TAKE_IMAGE, 1'b1, 1'b0));
    push_request(mk(EV_POLL,    32'hFFFF_FFFF, 8'd0, PK_COMMAND, CMD_FFC, 1'b0, 1'b1));
    push_request(mk(EV_TX_DONE, 32'hFFFF_FFFF, 8'd0, PK_COMMAND, CMD_FFC, 1'b0, 1'b0));
    push_request(mk(EV_POLL,    32'd0, 8'd0,   PK_COMMAND, CMD_FFC,     1'b0, 1'b0));
    push_request(mk(EV_TX_DONE, 32'd1, 8'd0,   PK_COMMAND, CMD_FFC,     1'b0, 1'b0));
    // image slot with no frame: gap timer restarts, nothing sent
    push_request(mk(EV_POLL,    32'd2, 8'd0,   PK_COMMAND, CMD_FFC,     1'b0, 1'b0));
    push_request(mk(EV_POLL,    32'd3, 8'd0,   PK_COMMAND, CMD_FFC,     1'b0, 1'b1));
    push_request(mk(EV_TX_DONE, 32'd4, 8'd0,   PK_COMMAND, CMD_FFC,     1'b0, 1'b0));
    // stream switching by packet and by command
    push_request(mk(EV_PACKET,  32'd5, 8'd1,   PK_STOP_LOSS, CMD_FFC,   1'b0, 1'b0));
    push_request(mk(EV_PACKET,  32'd6, 8'd1,   PK_GO,      CMD_FFC,     1'b0, 1'b0));
    push_request(mk(EV_PACKET,  32'd7, 8'd1,   PK_COMMAND, CMD_START_REC, 1'b1, 1'b0));
    push_request(mk(EV_PACKET,  32'd8, 8'd1,   PK_COMMAND, CMD_STOP_REC, 1'b1, 1'b0));
    push_request(mk(EV_PACKET,  32'd9, 8'd1,   PK_COMMAND, CMD_STREAM_ON, 1'b1, 1'b0));
    push_request(mk(EV_PACKET,  32'd10, 8'd1,  PK_STOP,    CMD_FFC,     1'b0, 1'b0));
    wait_drained();
    tb_now = 32'd20;

    for (int p = 0; p < 4; p++) begin
      program_phase(p);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // hold off mid-phase until every owed reply is back
        if (p == 1 && k == 50) wait_drained();
        push_request(random_request());
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ilcc_pkg.sv
rtl/ilcc_cfg_regs.sv
rtl/ilcc_ctrl.sv
rtl/image_link_capture_controller.sv
dv/ilcc_sb_pkg.sv
dv/tb_top.sv
